// File: rtl/assert_macros.svh
// Assertion macros for the RTL files of the indexed list engine.
// No dependencies; take in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ile_pkg.sv
// Package for the indexed list engine: sizes, operation and status codes,
// item and control structs. No dependencies.
`default_nettype none

package ile_pkg;

  // List capacity and word width
  localparam int DEPTH     = 64;
  localparam int ELEM_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = IDX_W + 1;

  // Operation codes
  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_GET    = 3'd2;
  localparam logic [2:0] KIND_SET    = 3'd3;
  localparam logic [2:0] KIND_SWAP   = 3'd4;
  localparam logic [2:0] KIND_FIND   = 3'd5;
  localparam logic [2:0] KIND_CLEAR  = 3'd6;

  // Status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_RANGE    = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_SAME     = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  index;
    logic [5:0]  second_index;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] data;
    logic [5:0]  position;
    logic [6:0]  count;
  } out_item_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic                 apply;
    logic [2:0]           kind;
    logic [6:0]           index;
    logic [IDX_W-1:0]     second_index;
    logic [ELEM_BITS-1:0] value;
    logic [CNT_W-1:0]     count;
    logic [ELEM_BITS-1:0] rd_a;
    logic [ELEM_BITS-1:0] rd_b;
  } cell_ctrl_t;

  // Per-cell contribution to the read and search trees
  typedef struct packed {
    logic [ELEM_BITS-1:0] tap_a;
    logic [ELEM_BITS-1:0] tap_b;
    logic                 match;
  } cell_tap_t;

  // Reduced read and search results
  typedef struct packed {
    logic [ELEM_BITS-1:0] rd_a;
    logic [ELEM_BITS-1:0] rd_b;
    logic                 found;
    logic [IDX_W-1:0]     position;
  } reduce_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REDUCE,
    ST_APPLY
  } state_t;

endpackage

`default_nettype wire

// File: rtl/ile_cell.sv
// One cell of the list: holds one entry, shifts to and from its neighbours,
// and offers its word and match bit to the reduction trees. Uses ile_pkg.
`default_nettype none

module ile_cell
  import ile_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic [IDX_W-1:0]     cell_idx,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic [ELEM_BITS-1:0] left_entry,
  input  wire logic [ELEM_BITS-1:0] right_entry,
  output      logic [ELEM_BITS-1:0] entry,
  output      cell_tap_t            tap
);

  logic [ELEM_BITS-1:0] entry_r, entry_nxt;
  cell_tap_t            tap_r, tap_nxt;
  logic                 idx_hit, idx2_hit, above;

  assign idx_hit  = (ctrl.index == {1'b0, cell_idx});
  assign idx2_hit = (ctrl.second_index == cell_idx);
  assign above    = ({1'b0, cell_idx} > ctrl.index);

  // Update the entry for the operation being applied
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.apply) begin
      case (ctrl.kind)
        KIND_INSERT: begin
          if (idx_hit) entry_nxt = ctrl.value;
          else if (above) entry_nxt = left_entry;
        end
        KIND_REMOVE: begin
          if (idx_hit || above) entry_nxt = right_entry;
        end
        KIND_SET: begin
          if (idx_hit) entry_nxt = ctrl.value;
        end
        KIND_SWAP: begin
          if (idx_hit) entry_nxt = ctrl.rd_b;
          else if (idx2_hit) entry_nxt = ctrl.rd_a;
        end
        default: entry_nxt = entry_r;
      endcase
    end
  end

  // Offer the word at the addressed positions and the search match
  always_comb begin
    tap_nxt.tap_a = idx_hit  ? entry_r : '0;
    tap_nxt.tap_b = idx2_hit ? entry_r : '0;
    tap_nxt.match = ({1'b0, cell_idx} < ctrl.count) && (entry_r == ctrl.value);
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    tap_r   <= tap_nxt;
  end

  assign entry = entry_r;
  assign tap   = tap_r;

endmodule

`default_nettype wire

// File: rtl/ile_reduce.sv
// Registered OR tree over the cell taps and first-match priority encoder.
// Uses ile_pkg.
`default_nettype none

module ile_reduce
  import ile_pkg::*;
(
  input  wire logic                   clk,
  input  wire cell_tap_t [DEPTH-1:0]  taps,
  output      reduce_res_t            res
);

  reduce_res_t res_r, res_nxt;

  // Merge the read words; keep the lowest matching position
  always_comb begin
    res_nxt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      res_nxt.rd_a = res_nxt.rd_a | taps[i].tap_a;
      res_nxt.rd_b = res_nxt.rd_b | taps[i].tap_b;
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (taps[i].match) begin
        res_nxt.found    = 1'b1;
        res_nxt.position = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

// File: rtl/ile_ctrl.sv
// Sequencer of the list: takes items, checks bounds, drives the cells,
// keeps the fill count and registers the result. Uses ile_pkg.
`default_nettype none

module ile_ctrl
  import ile_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire in_item_t    in_item,
  output      logic        busy,
  input  wire reduce_res_t res,
  output      cell_ctrl_t  cell_ctrl,
  output      logic        out_valid,
  output      out_item_t   out_item
);

  state_t          state_r, state_nxt;
  in_item_t        cmd_r;
  logic [2:0]      pre_status_r, pre_status_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;
  logic            accept;

  assign accept = start && !busy;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_SCAN;
      ST_SCAN:   state_nxt = ST_REDUCE;
      ST_REDUCE: state_nxt = ST_APPLY;
      ST_APPLY:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Bounds and capacity checks on the incoming item
  always_comb begin
    pre_status_nxt = STAT_OK;
    unique case (in_item.kind) inside
      KIND_INSERT: begin
        if (in_item.index > count_r) pre_status_nxt = STAT_RANGE;
        else if (count_r >= CNT_W'(DEPTH)) pre_status_nxt = STAT_FULL;
      end
      KIND_REMOVE, KIND_GET, KIND_SET: begin
        if (in_item.index >= count_r) pre_status_nxt = STAT_RANGE;
      end
      KIND_SWAP: begin
        if (in_item.index == {1'b0, in_item.second_index}) pre_status_nxt = STAT_SAME;
        else if ((in_item.index >= count_r) || ({1'b0, in_item.second_index} >= count_r))
          pre_status_nxt = STAT_RANGE;
      end
      KIND_FIND, KIND_CLEAR: pre_status_nxt = STAT_OK;
      default: pre_status_nxt = STAT_RANGE;
    endcase
  end

  // Outputs: handshake, cell broadcast and the result of the apply step
  always_comb begin
    busy                   = (state_r != ST_IDLE);
    cell_ctrl.apply        = (state_r == ST_APPLY) && (pre_status_r == STAT_OK);
    cell_ctrl.kind         = cmd_r.kind;
    cell_ctrl.index        = cmd_r.index;
    cell_ctrl.second_index = cmd_r.second_index;
    cell_ctrl.value        = cmd_r.value[ELEM_BITS-1:0];
    cell_ctrl.count        = count_r;
    cell_ctrl.rd_a         = res.rd_a;
    cell_ctrl.rd_b         = res.rd_b;

    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    if (state_r == ST_APPLY) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.status   = pre_status_r;
      out_item_nxt.data     = '0;
      out_item_nxt.position = '0;
      if (pre_status_r == STAT_OK) begin
        case (cmd_r.kind)
          KIND_INSERT: count_nxt = count_r + 1'b1;
          KIND_REMOVE: begin
            count_nxt         = count_r - 1'b1;
            out_item_nxt.data = 32'(res.rd_a);
          end
          KIND_GET:   out_item_nxt.data = 32'(res.rd_a);
          KIND_FIND: begin
            if (res.found) out_item_nxt.position = 6'(res.position);
            else out_item_nxt.status = STAT_NOTFOUND;
          end
          KIND_CLEAR: count_nxt = '0;
          default:    count_nxt = count_r;
        endcase
      end
      out_item_nxt.count = 7'(count_nxt);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: latch the item on accept, hold the result
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r        <= in_item;
      pre_status_r <= pre_status_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: rtl/indexed_list_engine_top.sv
// Indexed list engine: an ordered list of up to 64 words held in a chain of
// cells, with insert, remove, get, set, swap, find and clear operations.
// The result strobe (out_valid) lasts one cycle and cannot be held off. An
// item passes through these steps before the next item can be accepted:
// latch and check the item, the cells present their words and match bits,
// the OR tree and first-match encoder, the cells shift or write. The result
// appears the cycle after that write, while busy is already low.
// Uses ile_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module indexed_list_engine_top
  import ile_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire in_item_t  in_item,
  output      logic      busy,
  output      logic      out_valid,
  output      out_item_t out_item
);

  cell_ctrl_t                cell_ctrl;
  reduce_res_t               res;
  cell_tap_t [DEPTH-1:0]     taps;
  logic [ELEM_BITS-1:0]      entries [DEPTH];

  ile_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .res       (res),
    .cell_ctrl (cell_ctrl),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Chain of cells, each seeing its two neighbours
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ELEM_BITS-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entries[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entries[g+1];
    end
    ile_cell u_cell (
      .clk         (clk),
      .cell_idx    (IDX_W'(g)),
      .ctrl        (cell_ctrl),
      .left_entry  (left_w),
      .right_entry (right_w),
      .entry       (entries[g]),
      .tap         (taps[g])
    );
  end

  ile_reduce u_reduce (
    .clk  (clk),
    .taps (taps),
    .res  (res)
  );

  `ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy missing after accept")
  `ASSERT_IMP(a_latency, clk, rst_n, start && !busy, ##4 out_valid, "result strobe late")
  `ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe repeated")
  `ASSERT_IMP(a_count_cap, clk, rst_n, out_valid, out_item.count <= 7'(DEPTH), "count above capacity")

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for indexed_list_engine_top: directed, capacity and random list traffic.
// Expected results come from a list model inside the bench that is updated as each item is accepted.
// Depends on ile_pkg and the RTL of indexed_list_engine_top.
`timescale 1ns / 1ps

module tb_top
  import ile_pkg::*;
;

  // Spare operation code: the block must reject it with a range status
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  // List model: words held and fill level
  logic [ELEM_BITS-1:0] list_words [DEPTH];
  int                   list_count = 0;

  out_item_t awaited_replies [$];
  int        mismatch_count = 0;
  int        burst_left     = 0;
  int        idle_cycles    = 0;

  indexed_list_engine_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the list model and return the reply it yields
  function automatic out_item_t apply_list_op(input in_item_t op);
    out_item_t            reply;
    int                   n;
    int                   i;
    int                   ix;
    int                   ix2;
    bit                   hit;
    logic [ELEM_BITS-1:0] held;
    reply = '0;
    reply.status = STAT_OK;
    n = list_count;
    ix = int'(op.index);
    ix2 = int'(op.second_index);
    hit = 1'b0;
    case (op.kind)
      KIND_INSERT: begin
        if (ix > n) begin
          reply.status = STAT_RANGE;
        end else if (n >= DEPTH) begin
          reply.status = STAT_FULL;
        end else begin
          for (i = n; i > ix; i--) list_words[IDX_W'(i)] = list_words[IDX_W'(i - 1)];
          list_words[IDX_W'(ix)] = op.value;
          list_count = n + 1;
        end
      end
      KIND_REMOVE: begin
        if (ix >= n) begin
          reply.status = STAT_RANGE;
        end else begin
          reply.data = list_words[IDX_W'(ix)];
          for (i = ix; i + 1 < n; i++) list_words[IDX_W'(i)] = list_words[IDX_W'(i + 1)];
          list_count = n - 1;
        end
      end
      KIND_GET: begin
        if (ix >= n) reply.status = STAT_RANGE;
        else reply.data = list_words[IDX_W'(ix)];
      end
      KIND_SET: begin
        if (ix >= n) reply.status = STAT_RANGE;
        else list_words[IDX_W'(ix)] = op.value;
      end
      KIND_SWAP: begin
        if (ix == ix2) begin
          reply.status = STAT_SAME;
        end else if (ix >= n || ix2 >= n) begin
          reply.status = STAT_RANGE;
        end else begin
          held = list_words[IDX_W'(ix)];
          list_words[IDX_W'(ix)] = list_words[IDX_W'(ix2)];
          list_words[IDX_W'(ix2)] = held;
        end
      end
      KIND_FIND: begin
        reply.status = STAT_NOTFOUND;
        for (i = 0; i < n; i++) begin
          if (!hit && list_words[IDX_W'(i)] == op.value) begin
            hit = 1'b1;
            reply.status = STAT_OK;
            reply.position = i[5:0];
          end
        end
      end
      KIND_CLEAR: begin
        list_count = 0;
      end
      default: begin
        reply.status = STAT_RANGE;
      end
    endcase
    reply.count = list_count[6:0];
    return reply;
  endfunction

  function automatic in_item_t make_op(input logic [2:0] kind, input logic [6:0] index,
                                       input logic [5:0] second, input logic [31:0] value);
    in_item_t op;
    op.kind         = kind;
    op.index        = index;
    op.second_index = second;
    op.value        = value;
    return op;
  endfunction

  // Favour a few repeated words so that finds hit and duplicates occur
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      2:       w = $urandom_range(0, 3);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Draw one random operation, mostly in range, weighted towards growth or shrinkage
  function automatic in_item_t pick_list_op(input bit growing);
    in_item_t op;
    int       r;
    int       n;
    n = list_count;
    r = $urandom_range(0, 99);
    op.second_index = 6'($urandom);
    op.value = pick_word();
    if (r == 0) op.kind = growing ? KIND_GET : KIND_CLEAR;
    else if (r == 1) op.kind = KIND_UNUSED;
    else if (r < (growing ? 47 : 12)) op.kind = KIND_INSERT;
    else if (r < 57) op.kind = KIND_REMOVE;
    else if (r < 67) op.kind = KIND_GET;
    else if (r < 77) op.kind = KIND_SET;
    else if (r < 88) op.kind = KIND_SWAP;
    else op.kind = KIND_FIND;
    if ($urandom_range(0, 9) == 0) begin
      op.index = 7'($urandom);
    end else if (op.kind == KIND_INSERT) begin
      op.index = 7'($urandom_range(0, n));
    end else begin
      op.index = (n == 0) ? '0 : 7'($urandom_range(0, n - 1));
    end
    if (op.kind == KIND_SWAP && n > 0 && $urandom_range(0, 9) != 0)
      op.second_index = 6'($urandom_range(0, n - 1));
    if (op.kind == KIND_FIND && n > 0 && $urandom_range(0, 9) < 6)
      op.value = list_words[IDX_W'($urandom_range(0, n - 1))];
    return op;
  endfunction

  // Present one item, idling between bursts, and record its reply once accepted
  task automatic send_item(input in_item_t op);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= op;
    do @(posedge clk); while (busy);
    awaited_replies.push_back(apply_list_op(op));
  endtask

  // Hold the input off until every outstanding reply has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
  endtask

  // Empty-list errors, each operation, bounds, swap and find cases, spare code
  task automatic test_directed();
    send_item(make_op(KIND_GET, 0, 0, '0));
    send_item(make_op(KIND_REMOVE, 0, 0, '0));
    send_item(make_op(KIND_FIND, 0, 0, '0));
    send_item(make_op(KIND_SWAP, 0, 0, '0));
    send_item(make_op(KIND_SWAP, 0, 1, '0));
    send_item(make_op(KIND_SET, 0, 0, 32'h1111_1111));
    send_item(make_op(KIND_INSERT, 1, 0, 32'h2222_2222));
    send_item(make_op(KIND_INSERT, 0, 0, 32'h0000_0000));
    send_item(make_op(KIND_INSERT, 1, 0, 32'hFFFF_FFFF));
    send_item(make_op(KIND_INSERT, 0, 0, 32'h8000_0001));
    send_item(make_op(KIND_INSERT, 1, 0, 32'h1234_5678));
    send_item(make_op(KIND_GET, 3, 0, '0));
    send_item(make_op(KIND_GET, 4, 0, '0));
    send_item(make_op(KIND_GET, 7'h7F, 6'h3F, '1));
    send_item(make_op(KIND_SET, 2, 0, 32'hA5A5_A5A5));
    send_item(make_op(KIND_SWAP, 0, 3, '0));
    send_item(make_op(KIND_SWAP, 3, 6'h3F, '0));
    send_item(make_op(KIND_SWAP, 64, 0, '0));
    send_item(make_op(KIND_FIND, 0, 0, 32'hFFFF_FFFF));
    send_item(make_op(KIND_FIND, 0, 0, 32'hDEAD_BEEF));
    send_item(make_op(KIND_UNUSED, 0, 0, '0));
    send_item(make_op(KIND_REMOVE, 0, 0, '0));
    send_item(make_op(KIND_REMOVE, 2, 0, '0));
    send_item(make_op(KIND_CLEAR, 0, 0, '0));
    send_item(make_op(KIND_GET, 0, 0, '0));
  endtask

  // Fill the list to capacity, then probe the full and boundary cases
  task automatic test_capacity();
    int k;
    send_item(make_op(KIND_CLEAR, 0, 0, '0));
    for (k = 0; k < DEPTH; k++)
      send_item(make_op(KIND_INSERT, 7'($urandom_range(0, list_count)), 6'($urandom),
                        pick_word()));
    send_item(make_op(KIND_INSERT, 7'(DEPTH), 0, 32'h5555_5555));
    send_item(make_op(KIND_INSERT, 0, 0, 32'h5555_5555));
    send_item(make_op(KIND_INSERT, 7'(DEPTH + 1), 0, 32'h5555_5555));
    send_item(make_op(KIND_INSERT, 7'h7F, 0, 32'h5555_5555));
    send_item(make_op(KIND_GET, 7'(DEPTH - 1), 0, '0));
    send_item(make_op(KIND_SWAP, 0, 6'(DEPTH - 1), '0));
    send_item(make_op(KIND_FIND, 0, 0, list_words[DEPTH-1]));
    send_item(make_op(KIND_REMOVE, 7'(DEPTH - 1), 0, '0));
    send_item(make_op(KIND_INSERT, 7'(DEPTH - 1), 0, 32'hFFFF_FFFF));
    send_item(make_op(KIND_REMOVE, 0, 0, '0));
    drain_results();
  endtask

  // Alternate growing and shrinking phases, pausing for replies now and then
  task automatic test_random();
    int  sent;
    int  k;
    int  phase_len;
    bit  growing;
    sent = 0;
    growing = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(80, 200);
      for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        send_item(pick_list_op(growing));
        sent++;
      end
      growing = !growing;
      if ($urandom_range(0, 1) == 0) drain_results();
    end
  endtask

  // Compare each reply with the oldest outstanding one
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (awaited_replies.size() == 0) begin
        $error("reply with no item outstanding: status %0d count %0d",
               out_item.status, out_item.count);
        mismatch_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          mismatch_count++;
        end
        if (out_item.data !== want.data) begin
          $error("data: expected %h, got %h", want.data, out_item.data);
          mismatch_count++;
        end
        if (out_item.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_item.position);
          mismatch_count++;
        end
        if (out_item.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_item.count);
          mismatch_count++;
        end
      end
    end
  end

  // Stop the run if nothing is accepted or returned for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("indexed_list_engine_top regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_capacity();
    test_random();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("indexed_list_engine_top regression: pass");
    end else begin
      $display("indexed_list_engine_top regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/ile_pkg.sv
rtl/ile_cell.sv
rtl/ile_reduce.sv
rtl/ile_ctrl.sv
rtl/indexed_list_engine_top.sv
tb/sv/tb_top.sv
